FILE: rtl/daf_pkg.sv
// daf_pkg: shared types, codes and defaults for the dedup admission FIFO.
// No dependencies; imported by every module of the block.
package daf_pkg;

  localparam int DAF_QUEUE_DEPTH  = 64;
  localparam int DAF_FILTER_DEPTH = 256;

  localparam int KEY_W       = 64;
  localparam int LEN_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int QDEPTH_W    = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // opcodes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_POP     = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd5;
  localparam logic [STATUS_W-1:0] ST_POPPED      = 3'd6;
  localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY = 3'd7;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITEM_BYTES      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_QUEUE_ENTRIES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_LIMIT          = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REMEMBERED_KEYS = 2'd3;

  // register reset values
  localparam logic [31:0] MAX_ITEM_BYTES_RST      = 32'hFFFF_FFFF;
  localparam logic [6:0]  MAX_QUEUE_ENTRIES_RST   = 7'd64;
  localparam logic [31:0] BYTE_LIMIT_RST          = 32'hFFFF_FFFF;
  localparam logic [8:0]  MAX_REMEMBERED_KEYS_RST = 9'd256;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] item_key;
    logic [LEN_W-1:0] item_length;
  } daf_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                announced;
    logic [KEY_W-1:0]    popped_key;
    logic [LEN_W-1:0]    popped_length;
    logic [QDEPTH_W-1:0] queue_depth;
  } daf_result_t;

  // one queued entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] length;
  } daf_entry_t;

  // search token travelling along the filter chain
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [KEY_W-1:0] key;
  } daf_probe_t;

endpackage

FILE: rtl/daf_cell.sv
// daf_cell: one slot of the duplicate filter; holds a key and compares the passing probe.
// Depends on daf_pkg.
module daf_cell
  import daf_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  daf_probe_t       probe_in,
  output daf_probe_t       probe_out,
  input  logic [CNT_W-1:0] count,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_key
);

  logic [KEY_W-1:0] stored_key;
  logic             live;
  logic             match;

  // slot holds a remembered key only below the fill count
  assign live  = CNT_W'(IDX) < count;
  assign match = probe_in.valid && live && (probe_in.key == stored_key);

  always_ff @(posedge clk) begin
    if (wr_en && (count == CNT_W'(IDX))) begin
      stored_key <= wr_key;
    end
  end

  // only the valid bit needs a reset; hit and key ride along with it
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.hit <= probe_in.hit | match;
    probe_out.key <= probe_in.key;
  end

endmodule

FILE: rtl/daf_filter.sv
// daf_filter: row of daf_cell slots; a probe walks one slot per cycle.
// Depends on daf_pkg and daf_cell.
module daf_filter
  import daf_pkg::*;
#(
  parameter int DEPTH = DAF_FILTER_DEPTH,
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  daf_probe_t       probe_in,
  output daf_probe_t       probe_out,
  input  logic [CNT_W-1:0] count,
  input  logic             wr_en,
  input  logic [KEY_W-1:0] wr_key
);

  daf_probe_t chain [DEPTH+1];

  assign chain[0]  = probe_in;
  assign probe_out = chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    daf_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1]),
      .count     (count),
      .wr_en     (wr_en),
      .wr_key    (wr_key)
    );
  end

endmodule

FILE: rtl/daf_queue.sv
// daf_queue: entry store of the admission FIFO; one write port, one registered read port.
// Depends on daf_pkg.
module daf_queue
  import daf_pkg::*;
#(
  parameter int DEPTH  = DAF_QUEUE_DEPTH,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  daf_entry_t        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output daf_entry_t        rd_data
);

  daf_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dedup_admission_fifo_core.sv
// dedup_admission_fifo_core: top level of the admission FIFO with duplicate-key filter.
// Depends on daf_pkg, daf_filter (daf_cell) and daf_queue.
//
// Capture transactions (opcode 0) are checked for zero length, excess length, zero key
// and a repeated key, in that order; a fresh key sets announced even if the push then
// fails on the entry or byte limit. Pop transactions (opcode 1) return the head entry.
// The block works on one transaction at a time. The duplicate search is a row of
// FILTER_DEPTH cells: the probe key moves one cell per cycle, and a capture that reaches
// the search is not done until the probe has left the last cell. Captures refused before
// the search and pops of an empty queue go from the evaluation state straight to done;
// other pops pass through an extra state for the registered queue read.
// A finished result sits in the output register, and the next transaction is accepted
// while it waits; the block only stalls on completion if that register is still
// occupied. Queue and filter stores need no clearing after reset: fill counts bound
// every read.
module dedup_admission_fifo_core
  import daf_pkg::*;
#(
  parameter int QUEUE_DEPTH  = DAF_QUEUE_DEPTH,
  parameter int FILTER_DEPTH = DAF_FILTER_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  daf_item_t              item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output daf_result_t            result,
  // register writes
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int FCW = $clog2(FILTER_DEPTH + 1);
  localparam int ECW = (QCW > 7) ? QCW : 7;   // common width for the entry limit compare
  localparam int RCW = (FCW > 9) ? FCW : 9;   // common width for the filter limit compare

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // configuration registers
  logic [31:0] max_item_bytes;
  logic [6:0]  max_queue_entries;
  logic [31:0] byte_limit;
  logic [8:0]  max_remembered_keys;

  // control
  logic [2:0]  state, state_next;
  logic [QAW-1:0] head;
  logic [QCW-1:0] entry_count;
  logic [31:0]    byte_total;
  logic [FCW-1:0] remembered_count;

  // transaction being worked on
  logic             cur_op;
  logic [KEY_W-1:0] cur_key;
  logic [LEN_W-1:0] cur_len;

  // result waiting for commit, plus the state change it carries
  daf_result_t pend, pend_next;
  logic        pend_push, pend_push_next;
  logic        pend_pop, pend_pop_next;

  logic        item_take;
  logic        out_free;
  logic        commit;
  logic        too_large;
  logic        basic_ok;
  logic        queue_full;
  logic        bytes_over;
  logic        filter_room;
  logic [QCW:0]   tail_sum;
  logic [QAW-1:0] tail;
  logic [QAW-1:0] head_inc;

  daf_probe_t probe_inject;
  daf_probe_t probe_done;
  daf_entry_t rd_entry;
  daf_entry_t wr_entry;

  // ------------------------------------------------------------------
  // register writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_item_bytes      <= MAX_ITEM_BYTES_RST;
      max_queue_entries   <= MAX_QUEUE_ENTRIES_RST;
      byte_limit          <= BYTE_LIMIT_RST;
      max_remembered_keys <= MAX_REMEMBERED_KEYS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAX_ITEM_BYTES:      max_item_bytes      <= wr_data;
        REG_MAX_QUEUE_ENTRIES:   max_queue_entries   <= wr_data[6:0];
        REG_BYTE_LIMIT:          byte_limit          <= wr_data;
        REG_MAX_REMEMBERED_KEYS: max_remembered_keys <= wr_data[8:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // handshake
  // ------------------------------------------------------------------
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign commit     = (state == S_DONE) && out_free;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  assign too_large = cur_len > max_item_bytes;
  assign basic_ok  = (cur_len != '0) && !too_large && (cur_key != '0);

  // a full store counts as full even if the limit register is larger
  assign queue_full = (ECW'(entry_count) >= ECW'(max_queue_entries)) ||
                      (entry_count == QCW'(QUEUE_DEPTH));
  // byte sum compared in 33 bits, no wrap
  assign bytes_over = ({1'b0, byte_total} + {1'b0, cur_len}) > {1'b0, byte_limit};
  assign filter_room = (RCW'(remembered_count) < RCW'(max_remembered_keys)) &&
                       (remembered_count < FCW'(FILTER_DEPTH));

  // tail = (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum = (QCW+1)'(head) + (QCW+1)'(entry_count);
  assign tail = (tail_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
                QAW'(tail_sum - (QCW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
  assign head_inc = (head == QAW'(QUEUE_DEPTH - 1)) ? '0 : head + QAW'(1);

  // ------------------------------------------------------------------
  // duplicate filter chain
  // ------------------------------------------------------------------
  assign probe_inject.valid = (state == S_EVAL) && (cur_op == OP_CAPTURE) && basic_ok;
  assign probe_inject.hit   = 1'b0;
  assign probe_inject.key   = cur_key;

  daf_filter #(
    .DEPTH (FILTER_DEPTH),
    .CNT_W (FCW)
  ) u_filter (
    .clk       (clk),
    .rst       (rst),
    .probe_in  (probe_inject),
    .probe_out (probe_done),
    .count     (remembered_count),
    .wr_en     (commit && pend_push && filter_room),
    .wr_key    (cur_key)
  );

  // ------------------------------------------------------------------
  // entry store
  // ------------------------------------------------------------------
  assign wr_entry.key    = cur_key;
  assign wr_entry.length = cur_len;

  daf_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (QAW)
  ) u_queue (
    .clk     (clk),
    .wr_en   (commit && pend_push),
    .wr_addr (tail),
    .wr_data (wr_entry),
    .rd_en   ((state == S_EVAL) && (cur_op == OP_POP)),
    .rd_addr (head),
    .rd_data (rd_entry)
  );

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    pend_next      = pend;
    pend_push_next = pend_push;
    pend_pop_next  = pend_pop;
    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        pend_next.announced     = 1'b0;
        pend_next.popped_key    = '0;
        pend_next.popped_length = '0;
        pend_next.queue_depth   = QDEPTH_W'(entry_count);
        pend_push_next          = 1'b0;
        pend_pop_next           = 1'b0;
        if (cur_op == OP_POP) begin
          if (entry_count == '0) begin
            pend_next.status = ST_QUEUE_EMPTY;
            state_next       = S_DONE;
          end else begin
            state_next = S_POP;
          end
        end else if (cur_len == '0) begin
          pend_next.status = ST_EMPTY;
          state_next       = S_DONE;
        end else if (too_large) begin
          pend_next.status = ST_TOO_LARGE;
          state_next       = S_DONE;
        end else if (cur_key == '0) begin
          pend_next.status = ST_ZERO_KEY;
          state_next       = S_DONE;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_POP: begin
        // registered read data from the head slot is here now
        pend_next.status        = ST_POPPED;
        pend_next.popped_key    = rd_entry.key;
        pend_next.popped_length = rd_entry.length;
        pend_next.queue_depth   = QDEPTH_W'(entry_count - QCW'(1));
        pend_pop_next           = 1'b1;
        state_next              = S_DONE;
      end
      S_SEARCH: begin
        if (probe_done.valid) begin
          state_next = S_DONE;
          if (probe_done.hit) begin
            pend_next.status = ST_DUPLICATE;
          end else begin
            pend_next.announced = 1'b1;
            if (queue_full || bytes_over) begin
              pend_next.status = ST_FULL;
            end else begin
              pend_next.status      = ST_QUEUED;
              pend_next.queue_depth = QDEPTH_W'(entry_count + QCW'(1));
              pend_push_next        = 1'b1;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_push <= 1'b0;
      pend_pop  <= 1'b0;
    end else begin
      state     <= state_next;
      pend_push <= pend_push_next;
      pend_pop  <= pend_pop_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (item_take) begin
      cur_op  <= item.opcode;
      cur_key <= item.item_key;
      cur_len <= item.item_length;
    end
  end

  // ------------------------------------------------------------------
  // queue and filter bookkeeping, applied when the result is committed
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      head             <= '0;
      entry_count      <= '0;
      byte_total       <= '0;
      remembered_count <= '0;
    end else if (commit) begin
      if (pend_push) begin
        entry_count <= entry_count + QCW'(1);
        byte_total  <= byte_total + cur_len;
        if (filter_room) begin
          remembered_count <= remembered_count + FCW'(1);
        end
      end
      if (pend_pop) begin
        head        <= head_inc;
        entry_count <= entry_count - QCW'(1);
        byte_total  <= (pend.popped_length <= byte_total) ?
                       byte_total - pend.popped_length : '0;
      end
    end
  end

  // ------------------------------------------------------------------
  // output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result <= pend;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= QCW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_filter_bound: assert property (@(posedge clk) disable iff (rst)
    remembered_count <= FCW'(FILTER_DEPTH))
    else $error("remembered count beyond filter depth");

  a_probe_in_search: assert property (@(posedge clk) disable iff (rst)
    probe_done.valid |-> (state == S_SEARCH))
    else $error("filter probe finished outside the search phase");

  a_push_is_queued: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && pend_push) |-> ((pend.status == ST_QUEUED) && pend.announced
                                          && !pend_pop))
    else $error("push pending without a queued result");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && pend_pop) |-> (entry_count != '0))
    else $error("pop pending on an empty queue");
`endif

endmodule
